[sv/srr_pkg.sv]
// ----------------------------------------------------------------------------
// srr_pkg
// shared types and constants of the segment reorder receiver
// ----------------------------------------------------------------------------
`default_nettype none
package srr_pkg;
	localparam int WINDOW_SLOTS      = 32;
	localparam int MAX_SEGMENT_BYTES = 1024;
	localparam int SLOT_IDX_W        = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int OFF_W             = 31;
	localparam int LEN_W             = 11;
	localparam int KIND_W            = 2;

	localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EOF     = 2'd2;

	typedef enum logic [1:0] {
		CLS_EOF,
		CLS_BAD,
		CLS_DATA
	} cls_t;

	typedef struct packed {
		logic [OFF_W-1:0] seq;
		logic [LEN_W-1:0] len;
		cls_t             cls;
	} seg_entry_t;

	typedef struct packed {
		logic       valid;
		seg_entry_t entry;
	} seg_head_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DLV,
		S_RD,
		S_EV,
		S_INS,
		S_ACK,
		S_EOF
	} state_t;
endpackage
`default_nettype wire

[sv/srr_if.sv]
// ----------------------------------------------------------------------------
// srr channel interfaces
// segment header channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none
interface srr_seg_if;
	logic        valid;
	logic        ready;
	logic [30:0] seq_num;
	logic [10:0] data_len;
	modport source (output valid, seq_num, data_len, input ready);
	modport sink (input valid, seq_num, data_len, output ready);
endinterface

interface srr_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [30:0] offset_value;
	logic [10:0] deliver_len;
	logic        last_result;
	modport source (output valid, result_kind, offset_value, deliver_len, last_result,
		input ready);
	modport sink (input valid, result_kind, offset_value, deliver_len, last_result,
		output ready);
endinterface
`default_nettype wire

[sv/srr_front.sv]
// ----------------------------------------------------------------------------
// srr_front
// accepts segment headers, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none
module srr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	srr_seg_if.sink                seg_in,
	output srr_pkg::seg_head_t     head,
	input  wire logic              pop
);
	import srr_pkg::*;

	seg_entry_t buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	seg_entry_t in_entry;

	assign seg_in.ready = (count_q != 2'd2);
	assign push = seg_in.valid && seg_in.ready;

	always_comb begin
		in_entry.seq = seg_in.seq_num;
		in_entry.len = seg_in.data_len;
		if (seg_in.data_len == '0) begin
			in_entry.cls = CLS_EOF;
		end else if (32'(seg_in.data_len) > 32'(MAX_SEGMENT_BYTES)) begin
			in_entry.cls = CLS_BAD;
		end else begin
			in_entry.cls = CLS_DATA;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.entry = buf_q[rd_ptr_q];
endmodule
`default_nettype wire

[sv/srr_back.sv]
// ----------------------------------------------------------------------------
// srr_back
// slot engine: delivers, drains and buffers segments, gives acks
// ----------------------------------------------------------------------------
`default_nettype none
module srr_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  srr_pkg::seg_head_t     head,
	output logic                   pop,
	srr_res_if.source              res_out
);
	import srr_pkg::*;

	localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(WINDOW_SLOTS - 1);

	state_t                state_q, state_d;
	slot_t                 mem [WINDOW_SLOTS];
	slot_t                 rdata_q;
	logic [WINDOW_SLOTS-1:0] valid_q;
	logic [SLOT_IDX_W-1:0] idx_q;
	logic [SLOT_IDX_W-1:0] free_idx;
	logic                  free_any;
	logic [31:0]           exp_q;
	logic [OFF_W-1:0]      seq_q;
	logic [LEN_W-1:0]      len_q;
	logic                  drain_q;
	logic                  hit_q;
	logic                  dup_q;

	logic                  out_valid_q;
	logic [KIND_W-1:0]     out_kind_q;
	logic [OFF_W-1:0]      out_off_q;
	logic [LEN_W-1:0]      out_len_q;
	logic                  out_last_q;

	logic                  out_free;
	logic                  match;
	logic                  behind;
	logic                  end_pass;
	logic                  hit_now;
	logic                  advance;
	state_t                adv_state;
	logic                  emit;
	logic [KIND_W-1:0]     emit_kind;
	logic [OFF_W-1:0]      emit_off;
	logic [LEN_W-1:0]      emit_len;
	logic                  emit_last;
	logic                  head_eq;
	logic                  head_gt;

	assign out_free = !out_valid_q || res_out.ready;
	assign match    = ({1'b0, rdata_q.off} == exp_q);
	assign behind   = ({1'b0, rdata_q.off} < exp_q);
	assign end_pass = (idx_q == LAST_IDX);
	assign hit_now  = hit_q || (state_q == S_EV && drain_q && match);
	assign head_eq  = ({1'b0, head.entry.seq} == exp_q);
	assign head_gt  = ({1'b0, head.entry.seq} > exp_q);

	always_comb begin
		if (!end_pass) begin
			adv_state = S_RD;
		end else if (drain_q) begin
			adv_state = hit_now ? S_RD : S_ACK;
		end else begin
			adv_state = S_INS;
		end
	end

	// lowest free slot
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int k = WINDOW_SLOTS - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_idx = SLOT_IDX_W'(k);
				free_any = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (head.valid) begin
					unique case (head.entry.cls)
						CLS_EOF: state_d = S_EOF;
						CLS_DATA: begin
							if (head_eq) state_d = S_DLV;
							else if (head_gt) state_d = S_RD;
							else state_d = S_ACK;
						end
						default: state_d = S_ACK;
					endcase
				end
			end
			S_DLV: if (out_free) state_d = S_RD;
			S_RD: state_d = valid_q[idx_q] ? S_EV : adv_state;
			S_EV: begin
				if (!(drain_q && match && !out_free)) state_d = adv_state;
			end
			S_INS: state_d = S_ACK;
			S_ACK: if (out_free) state_d = S_IDLE;
			S_EOF: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		advance   = 1'b0;
		emit_kind = KIND_ACK;
		emit_off  = exp_q[31] ? '1 : exp_q[OFF_W-1:0];
		emit_len  = '0;
		emit_last = 1'b1;
		unique case (state_q)
			S_IDLE: pop = head.valid;
			S_DLV: begin
				emit      = out_free;
				emit_kind = KIND_DELIVER;
				emit_off  = seq_q;
				emit_len  = len_q;
				emit_last = 1'b0;
			end
			S_RD: advance = !valid_q[idx_q];
			S_EV: begin
				if (drain_q && match) begin
					emit    = out_free;
					advance = out_free;
				end else begin
					advance = 1'b1;
				end
				emit_kind = KIND_DELIVER;
				emit_off  = rdata_q.off;
				emit_len  = rdata_q.len;
				emit_last = 1'b0;
			end
			S_ACK: emit = out_free;
			S_EOF: begin
				emit      = out_free;
				emit_kind = KIND_EOF;
				emit_off  = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[idx_q];
		if (state_q == S_INS && !dup_q && free_any) begin
			mem[free_idx] <= '{off: seq_q, len: len_q};
		end
		if (pop) begin
			seq_q <= head.entry.seq;
			len_q <= head.entry.len;
		end
		if (emit) begin
			out_kind_q <= emit_kind;
			out_off_q  <= emit_off;
			out_len_q  <= emit_len;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			exp_q       <= '0;
			idx_q       <= '0;
			drain_q     <= 1'b0;
			hit_q       <= 1'b0;
			dup_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) out_valid_q <= 1'b1;
			else if (res_out.ready) out_valid_q <= 1'b0;
			if (pop) begin
				idx_q   <= '0;
				hit_q   <= 1'b0;
				dup_q   <= 1'b0;
				drain_q <= head_eq;
			end
			if (state_q == S_DLV && out_free) begin
				exp_q <= {1'b0, seq_q} + 32'(len_q);
			end
			if (state_q == S_EV) begin
				if (drain_q && match && out_free) begin
					exp_q          <= {1'b0, rdata_q.off} + 32'(rdata_q.len);
					valid_q[idx_q] <= 1'b0;
				end else if (drain_q && behind) begin
					// stale slot can never line up again
					valid_q[idx_q] <= 1'b0;
				end
				if (!drain_q && rdata_q.off == seq_q) dup_q <= 1'b1;
			end
			if (advance) begin
				idx_q <= end_pass ? '0 : idx_q + 1'b1;
				hit_q <= end_pass ? 1'b0 : hit_now;
			end
			if (state_q == S_INS && !dup_q && free_any) valid_q[free_idx] <= 1'b1;
			if (state_q == S_EOF && out_free) begin
				valid_q <= '0;
				exp_q   <= '0;
			end
		end
	end

	assign res_out.valid        = out_valid_q;
	assign res_out.result_kind  = out_kind_q;
	assign res_out.offset_value = out_off_q;
	assign res_out.deliver_len  = out_len_q;
	assign res_out.last_result  = out_last_q;
endmodule
`default_nettype wire

[sv/segment_reorder_receiver.sv]
// ----------------------------------------------------------------------------
// segment_reorder_receiver
// receive-side reorder of byte-sequenced segments with cumulative acks
// ----------------------------------------------------------------------------
//  channel   dir   fields
//  seg_in    in    seq_num[30:0], data_len[10:0]
//  res_out   out   result_kind[1:0], offset_value[30:0], deliver_len[10:0],
//                  last_result
//
//  end of file and oversized segments: straight to the result, no slot pass
//  in-order segment: one deliver, then passes over the 32 slots (read each
//  slot, evaluate each held slot), a new pass after each pass that delivered
//  ahead segment: one pass over the slots for the duplicate check, then insert
//  a two-entry queue takes new items while the slot engine works
//  results wait in an output register; a stall there holds the engine
//  reset clears the expected offset and all slot valid bits at once
// ----------------------------------------------------------------------------
`default_nettype none
module segment_reorder_receiver (
	input  wire logic  clk,
	input  wire logic  arst_n,
	srr_seg_if.sink    seg_in,
	srr_res_if.source  res_out
);
	import srr_pkg::*;

	seg_head_t head;
	logic      pop;

	srr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.seg_in (seg_in),
		.head   (head),
		.pop    (pop)
	);

	srr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.res_out (res_out)
	);
endmodule
`default_nettype wire

[sv/srr_checker.sv]
// ----------------------------------------------------------------------------
// srr_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
`default_nettype none
module srr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic [1:0]  result_kind,
	input wire logic [30:0] offset_value,
	input wire logic [10:0] deliver_len,
	input wire logic        last_result
);
	import srr_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(result_kind) && $stable(offset_value)
			&& $stable(deliver_len) && $stable(last_result))
		else $error("result changed while stalled");

	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind == KIND_EOF |-> last_result && offset_value == '0)
		else $error("bad end-of-file ack");

	a_dlv: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind == KIND_DELIVER |-> !last_result && deliver_len != '0)
		else $error("bad deliver item");

	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind != KIND_DELIVER |-> deliver_len == '0 && last_result)
		else $error("ack with length or not last");
endmodule

bind segment_reorder_receiver srr_checker u_srr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (res_out.valid),
	.ready        (res_out.ready),
	.result_kind  (res_out.result_kind),
	.offset_value (res_out.offset_value),
	.deliver_len  (res_out.deliver_len),
	.last_result  (res_out.last_result)
);
`default_nettype wire
